// ===== sv/ftb_pkg.sv =====
// filter_timer_bank package: bank size, operation and status codes, register indexes
// transaction types for the item and result channels, controller/datapath command and status structs
// no dependencies
package ftb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_INIT  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	localparam logic [1:0] ST_EXPIRED = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [0:0] REG_FILTER_TIME = 1'b0;
	localparam logic [0:0] REG_PRESCALE    = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] timer_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       prescale_wrap;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic prescale;
		logic single;
		logic walk;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_init;
		logic wrap_hit;
		logic cur_last;
	} dp_stat_t;

endpackage

// ===== sv/ftb_ctrl.sv =====
// filter_timer_bank controller: sequences one transaction through capture, execute,
// timer walk and result cycles; depends on ftb_pkg
module ftb_ctrl
	import ftb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_tick) begin
					cmd.prescale = 1'b1;
					state_d      = stat.wrap_hit ? S_WALK : S_DONE;
				end else begin
					cmd.single = 1'b1;
					state_d    = stat.is_init ? S_WALK : S_DONE;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.cur_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== sv/ftb_dp.sv =====
// filter_timer_bank datapath: config registers, prescaler, active mask, timer bank
// and result registers; depends on ftb_pkg
module ftb_dp
	import ftb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output rsp_t       rsp
);

	logic [7:0]            filter_q;
	logic [7:0]            period_q;
	logic [7:0]            cnt_q;
	logic [NUM_TIMERS-1:0] mask_q;
	logic [7:0]            tv_q [NUM_TIMERS];
	logic [TIDX_W-1:0]     cur_q;
	logic [1:0]            func_q;
	logic [3:0]            idx_q;
	logic [1:0]            status_q;
	logic                  wrap_q;

	logic [7:0]        cnt_inc;
	logic [TIDX_W-1:0] sel;
	logic [7:0]        rd_val;
	logic              idx_ok;

	assign cnt_inc = cnt_q + 8'd1;
	assign sel     = cmd.walk ? cur_q : idx_q[TIDX_W-1:0];
	assign rd_val  = tv_q[sel];
	assign idx_ok  = (idx_q < 4'(NUM_TIMERS));

	assign stat.is_tick  = (func_q == OP_TICK);
	assign stat.is_init  = (func_q == OP_INIT);
	assign stat.wrap_hit = (cnt_inc == period_q);
	assign stat.cur_last = (cur_q == TIDX_W'(NUM_TIMERS - 1));

	assign rsp.status        = status_q;
	assign rsp.prescale_wrap = wrap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 8'd1;
			period_q <= 8'd1;
			cnt_q    <= '0;
			mask_q   <= '0;
			tv_q     <= '{default: '0};
			cur_q    <= '0;
			func_q   <= OP_TICK;
			idx_q    <= '0;
			status_q <= ST_EXPIRED;
			wrap_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FILTER_TIME: filter_q <= cfg_data;
					REG_PRESCALE:    period_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				func_q   <= req.func;
				idx_q    <= req.timer_index;
				cur_q    <= '0;
				status_q <= ST_EXPIRED;
				wrap_q   <= 1'b0;
			end
			if (cmd.prescale) begin
				if (cnt_inc == period_q) begin
					cnt_q  <= '0;
					wrap_q <= 1'b1;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (cmd.single) begin
				case (func_q)
					OP_INIT: begin
						cnt_q  <= '0;
						mask_q <= '0;
					end
					OP_START: begin
						if (idx_ok) begin
							if (!mask_q[sel]) begin
								mask_q[sel] <= 1'b1;
								tv_q[sel]   <= filter_q;
								status_q    <= (filter_q != '0) ? ST_RUNNING : ST_EXPIRED;
							end else begin
								status_q <= (rd_val != '0) ? ST_RUNNING : ST_EXPIRED;
							end
						end else begin
							status_q <= ST_INVALID;
						end
					end
					OP_STOP: begin
						if (idx_ok) begin
							mask_q[sel] <= 1'b0;
							tv_q[sel]   <= filter_q;
						end
					end
					default: ;
				endcase
			end
			if (cmd.walk) begin
				if (func_q == OP_INIT) begin
					tv_q[sel] <= filter_q;
				end else if (mask_q[sel] && (rd_val != '0)) begin
					tv_q[sel] <= rd_val - 8'd1;
				end
				cur_q <= cur_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/filter_timer_bank.sv =====
// filter_timer_bank top level: connects controller and datapath, config write channel
// depends on ftb_pkg, ftb_ctrl, ftb_dp
//
// One transaction at a time: start is taken when busy is low, and the result is valid on
// rsp while done is high for a single cycle, which the receiver cannot stall. Start, stop
// and ticks that do not wrap pass through capture, execute and result; init and a tick
// that wraps the prescaler also walk the timer bank, one timer per cycle, between
// execute and result. busy stays high in the cycle done is shown and falls in the cycle
// after it, so the next start is taken at the earliest in the cycle after done.
// Config writes are always ready and should be issued only while busy is low.
module filter_timer_bank
	import ftb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ctl_busy;

	assign cfg_ready = 1'b1;
	assign busy      = ctl_busy;

	ftb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (ctl_busy),
		.done   (done)
	);

	ftb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// ===== sv/ftb_chk.sv =====
// filter_timer_bank port checker and its bind to the top level
// depends on ftb_pkg and filter_timer_bank
module ftb_chk
	import ftb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// a transaction in makes the block busy on the next cycle
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result closes the transaction, so no two strobes in a row
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// a result strobe never appears without an accepted transaction behind it
	a_owned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// a wrap only comes from a tick, whose status is expired
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.prescale_wrap) |-> (rsp.status == ST_EXPIRED))
		else $error("wrap reported with nonzero status");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_EXPIRED || rsp.status == ST_RUNNING ||
			rsp.status == ST_INVALID))
		else $error("undefined status code");

endmodule

bind filter_timer_bank ftb_chk u_ftb_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
